>>> design/sss_pkg.sv
`timescale 1ns / 1ps
package sss_pkg;
  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned CoefBits   = 32;
  localparam int unsigned RegBits    = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned IdxBits    = 10;

  localparam logic [1:0] FuncStep   = 2'd0;
  localparam logic [1:0] FuncExcite = 2'd1;
  localparam logic [1:0] FuncRead   = 2'd2;

  localparam logic [CfgIdxBits-1:0] RegB0   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegB1   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegB2   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegC0   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegC1   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegGrid = 3'd5;
endpackage

>>> design/sss_ram.sv
`timescale 1ns / 1ps
module sss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/stiff_string_stencil_step.sv
`timescale 1ns / 1ps
// Step: clearing of all three banks comes first after reset (no item taken). A step
//   sweeps the grid one point a cycle.
// Excite: read, write back, read out, result. Read: read out, result.
// One item at a time; busy is high from acceptance until the result strobe.
// Each result shows for exactly one cycle on done_o; the receiver cannot stall.
// Reset (rst_ni low) clears coefficients to zero, grid_q to 1023, rotation to zero.
module stiff_string_stencil_step #(
  parameter int unsigned MaxPoints  = sss_pkg::MaxPoints,
  parameter int unsigned SampleBits = sss_pkg::SampleBits,
  parameter int unsigned CoefBits   = sss_pkg::CoefBits,
  localparam int unsigned AddrBits  = $clog2(MaxPoints),
  localparam int unsigned CntBits   = AddrBits + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func_i,
  input  logic [sss_pkg::IdxBits-1:0]         index_i,
  input  logic signed [SampleBits-1:0]        value_i,
  input  logic                                cfg_we_i,
  input  logic [sss_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [sss_pkg::RegBits-1:0]         cfg_data_i,
  output logic                                done_o,
  output logic signed [SampleBits-1:0]        sample_o,
  output logic                                saturated_o
);
  localparam int unsigned ProdBits = SampleBits + 1 + CoefBits;
  localparam int unsigned AccBits  = ProdBits + 3;
  localparam int unsigned CoefFrac = CoefBits - 4;
  localparam logic [2:0] StClr = 3'd0, StIdle = 3'd1, StSweep = 3'd2, StExR = 3'd3,
                         StExW = 3'd4, StRdA = 3'd5, StRdB = 3'd6, StOut = 3'd7;

  logic [2:0] st_q, st_d;
  logic signed [CoefBits-1:0] b0_q, b1_q, b2_q, c0_q, c1_q;
  logic [sss_pkg::IdxBits-1:0] grid_q;
  logic [1:0] rot_q;
  logic [1:0] func_q;
  logic [sss_pkg::IdxBits-1:0] idx_q;
  logic signed [SampleBits-1:0] val_q;
  logic sat_q;
  logic [CntBits-1:0] cnt_q;
  logic signed [SampleBits-1:0] samp_q;
  logic done_q;

  // grid length clipped to storage
  logic [CntBits-1:0] n_w;
  always_comb begin
    if ({{(32-sss_pkg::IdxBits){1'b0}}, grid_q} > MaxPoints - 1) n_w = CntBits'(MaxPoints - 1);
    else n_w = CntBits'(grid_q);
  end

  // physical bank for role r (0 next, 1 now, 2 before)
  function automatic logic [1:0] phys(input logic [1:0] r, input logic [1:0] rot);
    logic [2:0] s;
    s = {1'b0, r} + {1'b0, rot};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  logic [1:0] pnx, pnw, pbf;
  assign pnx = phys(2'd0, rot_q);
  assign pnw = phys(2'd1, rot_q);
  assign pbf = phys(2'd2, rot_q);

  logic                 we   [3];
  logic [AddrBits-1:0]  wa   [3];
  logic [SampleBits-1:0] wd  [3];
  logic [AddrBits-1:0]  ra   [3];
  logic [SampleBits-1:0] rd  [3];

  for (genvar g = 0; g < 3; g++) begin : g_bank
    sss_ram #(.Width(SampleBits), .Depth(MaxPoints)) u_ram (
      .clk_i, .we_i(we[g]), .waddr_i(wa[g]), .wdata_i(wd[g]),
      .raddr_i(ra[g]), .rdata_o(rd[g])
    );
  end

  // sweep: read address cnt_q; window of now / before samples shifts in
  logic signed [SampleBits-1:0] nw_win [5];
  logic signed [SampleBits-1:0] bf_win [3];
  logic rv_q;
  logic [CntBits-1:0] rcnt_q;
  // pipeline: stage A products, stage B sum; rounding is combinational on the sum
  logic signed [ProdBits-1:0] p0_q, p1_q, p2_q, p3_q, p4_q;
  logic sa_v_q, sb_v_q;
  logic sa_in_q, sb_in_q;
  logic [CntBits-1:0] sa_l_q, sb_l_q;
  logic signed [AccBits-1:0] acc_q;

  logic signed [SampleBits-1:0] cur_nw, cur_bf;
  assign cur_nw = rd[pnw];
  assign cur_bf = rd[pbf];

  // centre point of the window is rcnt - 2
  logic [CntBits-1:0] ctr_l;
  assign ctr_l = rcnt_q - CntBits'(2);

  // round and saturate
  localparam logic signed [AccBits-1:0] Half = AccBits'(1) <<< (CoefFrac - 1);
  localparam logic signed [AccBits-1:0] SatHi =
    AccBits'(signed'({1'b0, {(SampleBits-1){1'b1}}}));
  localparam logic signed [AccBits-1:0] SatLo = -SatHi - AccBits'(1);
  logic signed [AccBits-1:0] rsum, shd;
  logic signed [SampleBits-1:0] rnd;
  logic rsat;
  always_comb begin
    rsum = acc_q + Half;
    shd  = rsum >>> CoefFrac;
    rsat = 1'b0;
    if (shd > SatHi) begin
      rnd = {1'b0, {(SampleBits-1){1'b1}}}; rsat = 1'b1;
    end else if (shd < SatLo) begin
      rnd = {1'b1, {(SampleBits-1){1'b0}}}; rsat = 1'b1;
    end else begin
      rnd = shd[SampleBits-1:0];
    end
  end

  // excite: clipped point and saturating adds
  logic [CntBits-1:0] xp;
  always_comb begin
    xp = CntBits'(idx_q);
    if (xp < CntBits'(2)) xp = CntBits'(2);
    if (xp > n_w - CntBits'(2)) xp = n_w - CntBits'(2);
  end
  function automatic logic [SampleBits:0] sadd(input logic signed [SampleBits-1:0] a,
                                              input logic signed [SampleBits-1:0] b);
    logic signed [SampleBits:0] s;
    s = {a[SampleBits-1], a} + {b[SampleBits-1], b};
    if (s[SampleBits] != s[SampleBits-1])
      return {1'b1, s[SampleBits], {(SampleBits-1){~s[SampleBits]}}};
    return {1'b0, s[SampleBits-1:0]};
  endfunction
  logic [SampleBits:0] xnw, xbf;
  assign xnw = sadd(cur_nw, val_q);
  assign xbf = sadd(cur_bf, val_q);

  logic idx_ok;
  assign idx_ok = {{(32-sss_pkg::IdxBits){1'b0}}, idx_q} < MaxPoints;

  logic [CntBits-1:0] sweep_end;
  assign sweep_end = CntBits'(MaxPoints);

  always_comb begin
    st_d = st_q;
    for (int b = 0; b < 3; b++) begin
      we[b] = 1'b0; wa[b] = '0; wd[b] = '0; ra[b] = cnt_q[AddrBits-1:0];
    end
    unique case (st_q)
      StClr: begin
        for (int b = 0; b < 3; b++) begin
          we[b] = 1'b1; wa[b] = cnt_q[AddrBits-1:0];
        end
        if (cnt_q == CntBits'(MaxPoints - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          priority if (func_i == sss_pkg::FuncStep) st_d = StSweep;
          else if (func_i == sss_pkg::FuncExcite) st_d = StExR;
          else st_d = StRdA;
        end
      end
      StSweep: begin
        if (sb_v_q) begin
          we[pnx] = 1'b1; wa[pnx] = sb_l_q[AddrBits-1:0];
          wd[pnx] = sb_in_q ? rnd : '0;
        end
        if (!rv_q && !sa_v_q && !sb_v_q && cnt_q == sweep_end && rcnt_q == sweep_end)
          st_d = StRdA;
      end
      StExR: begin
        ra[pnw] = xp[AddrBits-1:0]; ra[pbf] = xp[AddrBits-1:0];
        st_d = StExW;
      end
      StExW: begin
        if (n_w >= 4) begin
          we[pnw] = 1'b1; wa[pnw] = xp[AddrBits-1:0]; wd[pnw] = xnw[SampleBits-1:0];
          we[pbf] = 1'b1; wa[pbf] = xp[AddrBits-1:0]; wd[pbf] = xbf[SampleBits-1:0];
        end
        st_d = StRdA;
      end
      StRdA: begin
        ra[pnw] = AddrBits'(idx_q);
        st_d = StRdB;
      end
      StRdB: st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; cnt_q <= '0; rot_q <= '0; done_q <= 1'b0; sat_q <= 1'b0;
      b0_q <= '0; b1_q <= '0; b2_q <= '0; c0_q <= '0; c1_q <= '0;
      grid_q <= sss_pkg::IdxBits'(1023);
      rv_q <= 1'b0; sa_v_q <= 1'b0; sb_v_q <= 1'b0; rcnt_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= (st_q == StOut);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sss_pkg::RegB0:   b0_q <= CoefBits'(signed'(cfg_data_i));
          sss_pkg::RegB1:   b1_q <= CoefBits'(signed'(cfg_data_i));
          sss_pkg::RegB2:   b2_q <= CoefBits'(signed'(cfg_data_i));
          sss_pkg::RegC0:   c0_q <= CoefBits'(signed'(cfg_data_i));
          sss_pkg::RegC1:   c1_q <= CoefBits'(signed'(cfg_data_i));
          sss_pkg::RegGrid: grid_q <= cfg_data_i[sss_pkg::IdxBits-1:0];
          default: ;
        endcase
      end
      unique case (st_q)
        StClr: cnt_q <= cnt_q + CntBits'(1);
        StIdle: begin
          cnt_q <= '0; rcnt_q <= '0; rv_q <= 1'b0; sat_q <= 1'b0;
        end
        StSweep: begin
          if (cnt_q != sweep_end) cnt_q <= cnt_q + CntBits'(1);
          rv_q <= (cnt_q != sweep_end);
          if (rv_q) rcnt_q <= rcnt_q + CntBits'(1);
          // extra flush beats shift zeros past the right end
          sa_v_q <= rv_q && rcnt_q >= CntBits'(2) || (!rv_q && rcnt_q == sweep_end &&
                    sa_l_q + CntBits'(1) < sweep_end && sa_v_q);
          sb_v_q <= sa_v_q;
          if (sb_v_q && sb_in_q && rsat) sat_q <= 1'b1;
          if (st_d == StRdA) rot_q <= (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;
        end
        StExW: if (n_w >= 4 && (xnw[SampleBits] || xbf[SampleBits])) sat_q <= 1'b1;
        StOut: ;
        default: ;
      endcase
    end
  end

  // window registers and pipeline payload
  logic signed [SampleBits-1:0] in_nw, in_bf;
  assign in_nw = rv_q ? cur_nw : '0;
  assign in_bf = rv_q ? cur_bf : '0;
  logic [CntBits-1:0] sa_l_d;
  logic sa_in_d;
  always_comb begin
    sa_l_d = rv_q ? ctr_l : sa_l_q + CntBits'(1);
    sa_in_d = (sa_l_d >= CntBits'(2)) && (sa_l_d + CntBits'(2) <= n_w) && (n_w >= 4);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle) begin
      for (int k = 0; k < 5; k++) nw_win[k] <= '0;
      for (int k = 0; k < 3; k++) bf_win[k] <= '0;
      sa_l_q <= '0;
    end else if (st_q == StSweep) begin
      nw_win[4] <= in_nw;
      for (int k = 0; k < 4; k++) nw_win[k] <= nw_win[k+1];
      bf_win[2] <= in_bf;
      for (int k = 0; k < 2; k++) bf_win[k] <= bf_win[k+1];
      // products use the current window registers: centre = nw_win[3] / bf_win[1]
      p0_q <= ProdBits'(nw_win[3]) * ProdBits'(b0_q);
      p1_q <= (ProdBits'(nw_win[4]) + ProdBits'(nw_win[2])) * ProdBits'(b1_q);
      p2_q <= (ProdBits'(in_nw) + ProdBits'(nw_win[1])) * ProdBits'(b2_q);
      p3_q <= ProdBits'(bf_win[1]) * ProdBits'(c0_q);
      p4_q <= (ProdBits'(bf_win[2]) + ProdBits'(bf_win[0])) * ProdBits'(c1_q);
      sa_l_q <= sa_l_d;
      sa_in_q <= sa_in_d;
      acc_q <= AccBits'(p0_q) + AccBits'(p1_q) + AccBits'(p2_q) + AccBits'(p3_q)
             + AccBits'(p4_q);
      sb_l_q <= sa_l_q;
      sb_in_q <= sa_in_q;
    end
    if (st_q == StExR || st_q == StSweep || st_q == StExW) func_q <= func_q;
    if (st_q == StIdle && start) begin
      func_q <= func_i; idx_q <= index_i; val_q <= value_i;
    end
    if (st_q == StRdB) samp_q <= idx_ok ? cur_nw : '0;
  end

  assign busy        = (st_q != StIdle);
  assign done_o      = done_q;
  assign sample_o    = samp_q;
  assign saturated_o = sat_q && (func_q == sss_pkg::FuncStep || func_q == sss_pkg::FuncExcite);

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy || st_q == StClr
    || $past(st_q) == StOut)
    else $error("result strobe outside output slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == StIdle && start) |=> busy)
    else $error("item accepted without busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $countones({we[0], we[1], we[2]}) <= 2
    || st_q == StClr)
    else $error("more than two banks written at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rot_q != 2'd3)
    else $error("bank rotation out of range");
endmodule
